[sv/dlf_pkg.sv]
package dlf_pkg;

  localparam int NEURONS_DEF = 16;
  localparam int INPUTS_DEF  = 64;
  localparam int MAX_RESULTS = 16;
  localparam int VAL_W       = 16;
  localparam int ACC_W       = 40;
  localparam int SEL_W       = 4;
  localparam int POS_W       = 6;
  localparam int CFG_W       = 5;

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_ELEM   = 2'd2;

  localparam logic [1:0] ACT_RELU = 2'd0;
  localparam logic [1:0] ACT_SIG  = 2'd1;
  localparam logic [1:0] ACT_TANH = 2'd2;

  localparam logic REG_ACT_MODE     = 1'b0;
  localparam logic REG_NEURON_COUNT = 1'b1;

  localparam logic [63:0] QONE = 64'h1000_0000_0000_0000;

  // broadcast to every cell
  typedef struct packed {
    logic              load_w;
    logic              load_b;
    logic              elem;
    logic              cap;
    logic              shift;
    logic [SEL_W-1:0]  sel;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
  } cell_bus_t;

  // finished sum and bias travelling down the chain
  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [VAL_W-1:0] bias;
  } hold_t;

  typedef logic [255:0][VAL_W-1:0] act_table_t;

  // shift-subtract quotient, elaboration only
  function automatic logic [63:0] udiv(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[123:60];
  endfunction

  // round-half-up of num/den in Q.12, num <= den
  function automatic logic [VAL_W-1:0] qratio(logic [63:0] num, logic [63:0] den);
    logic [127:0] r;
    logic [127:0] d;
    logic [14:0]  q;
    r = {64'b0, num} << 13;
    d = {64'b0, den};
    q = '0;
    for (int i = 13; i >= 0; i--) begin
      if (r >= (d << i)) begin
        r = r - (d << i);
        q[i] = 1'b1;
      end
    end
    q = (q + 15'd1) >> 1;
    return VAL_W'(q);
  endfunction

  function automatic act_table_t build_table(logic is_tanh);
    logic [63:0] pw [0:128];
    logic [63:0] e;
    logic [63:0] term;
    logic [63:0] p;
    logic [63:0] p2;
    logic [VAL_W-1:0] t;
    act_table_t tab;
    int k;
    e = QONE;
    term = QONE;
    for (int n = 1; n <= 20; n++) begin
      term = udiv(term, 64'(16 * n));
      if ((n % 2) == 1) e = e - term;
      else e = e + term;
    end
    pw[0] = QONE;
    for (int n = 1; n <= 128; n++) pw[n] = qmul(pw[n-1], e);
    for (int idx = 0; idx < 256; idx++) begin
      k = (idx < 128) ? idx : idx - 256;
      p = pw[(k < 0) ? -k : k];
      p2 = qmul(p, p);
      if (is_tanh) begin
        t = qratio(QONE - p2, QONE + p2);
        tab[idx] = (k < 0) ? VAL_W'(-t) : t;
      end else begin
        tab[idx] = qratio((k >= 0) ? QONE : p, QONE + p);
      end
    end
    return tab;
  endfunction

  localparam act_table_t SIG_TABLE  = build_table(1'b0);
  localparam act_table_t TANH_TABLE = build_table(1'b1);

endpackage

[sv/dense_layer_forward.sv]
// Dense layer, inference only.
// Input channel (in_valid / in_stall): each item loads a weight, loads a
// bias, or streams one input element. Loads and elements are taken one per
// cycle while in_stall is low; an element is multiplied by every active
// neuron's weight in a row of neuron cells and summed into that cell's
// 40-bit accumulator. An element marked last ends the vector: in_stall
// stays high for the drain, while the sums are captured and one result per
// active neuron is unloaded, and longer if the output stalls. The
// multiply-accumulate pipe in each cell sets the one-element-per-cycle rate.
// Result channel (out_valid / out_stall): one item per active neuron, in
// neuron order, out_last on the final one, each from the chain head through
// the finishing stage and the output register. These two hold while
// out_stall is high; the chain simply stops shifting.
// Config port: cfg_wr_en with cfg_index (0 act_mode, 1 neuron_count)
// and cfg_data, only written by the user while idle (not enforced).
// Reset (rst_n low, synchronous) clears accumulators, control and config;
// weight and bias memories keep whatever they held.
module dense_layer_forward #(
  parameter int NEURONS = dlf_pkg::NEURONS_DEF,
  parameter int INPUTS  = dlf_pkg::INPUTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_cmd,
  input  logic [dlf_pkg::SEL_W-1:0]   in_neuron_sel,
  input  logic [dlf_pkg::POS_W-1:0]   in_input_pos,
  input  logic signed [dlf_pkg::VAL_W-1:0] in_value,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dlf_pkg::SEL_W-1:0]   out_neuron,
  output logic signed [dlf_pkg::VAL_W-1:0] out_value,
  output logic                        out_last,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [dlf_pkg::CFG_W-1:0]   cfg_data
);

  // at most 16 neurons are addressable and reported
  localparam int NC = (NEURONS < dlf_pkg::MAX_RESULTS) ? NEURONS : dlf_pkg::MAX_RESULTS;
  localparam logic [dlf_pkg::CFG_W-1:0] NC5 = dlf_pkg::CFG_W'(NC);

  typedef enum logic [1:0] {S_RUN, S_FLUSH, S_UNLOAD} state_t;

  state_t                      state_r;
  logic [1:0]                  act_mode_r;
  logic [dlf_pkg::CFG_W-1:0]   ncount_r, cnt;
  logic                        accept, last_elem;
  logic                        l1_r, l2_r;
  logic [dlf_pkg::CFG_W-1:0]   rem_r;
  logic [dlf_pkg::SEL_W-1:0]   idx_r;
  logic                        shift;
  dlf_pkg::cell_bus_t          bus;
  logic [NC-1:0]               active;
  dlf_pkg::hold_t              hold_w [NC+1];

  // finishing stage
  logic                        a_v_r, a_last_r, a_take, b_can;
  logic [dlf_pkg::SEL_W-1:0]   a_neu_r;
  logic [dlf_pkg::VAL_W-1:0]   a_s_r, s_nxt, act_val;
  logic [41:0]                 y_sum;
  logic [29:0]                 s_wide;
  logic                        ovf;
  logic                        out_valid_r, out_last_r;
  logic [dlf_pkg::SEL_W-1:0]   out_neu_r;
  logic [dlf_pkg::VAL_W-1:0]   out_val_r;

  assign in_stall  = (state_r != S_RUN);
  assign accept    = in_valid & ~in_stall;
  assign last_elem = accept & (in_cmd == dlf_pkg::CMD_ELEM) & in_last;

  always_comb begin
    if (ncount_r == '0) cnt = dlf_pkg::CFG_W'(1);
    else if (ncount_r > NC5) cnt = NC5;
    else cnt = ncount_r;
  end

  assign b_can  = ~out_valid_r | ~out_stall;
  assign a_take = ~a_v_r | b_can;
  assign shift  = (state_r == S_UNLOAD) & a_take;

  always_comb begin
    bus.load_w = accept & (in_cmd == dlf_pkg::CMD_WEIGHT);
    bus.load_b = accept & (in_cmd == dlf_pkg::CMD_BIAS);
    bus.elem   = accept & (in_cmd == dlf_pkg::CMD_ELEM);
    bus.cap    = l2_r;
    bus.shift  = shift;
    bus.sel    = in_neuron_sel;
    bus.pos    = in_input_pos;
    bus.value  = in_value;
  end

  // row of neuron cells; cell 0 is the head of the unload chain
  assign hold_w[NC] = '0;
  for (genvar i = 0; i < NC; i++) begin : g_cell
    assign active[i] = (32'(i) < 32'(cnt));
    dlf_cell #(.INPUTS(INPUTS), .IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bus      (bus),
      .active   (active[i]),
      .hold_in  (hold_w[i+1]),
      .hold_out (hold_w[i])
    );
  end

  // bias add, round half up to Q4.12, saturate
  always_comb begin
    y_sum = {{2{hold_w[0].acc[39]}}, hold_w[0].acc}
          + {{14{hold_w[0].bias[15]}}, hold_w[0].bias, 12'b0}
          + 42'd2048;
    s_wide = y_sum[41:12];
    ovf = (s_wide[29:15] != {15{s_wide[29]}});
    if (ovf) s_nxt = s_wide[29] ? 16'h8000 : 16'h7fff;
    else s_nxt = s_wide[15:0];
  end

  always_comb begin
    case (act_mode_r)
      dlf_pkg::ACT_SIG:  act_val = dlf_pkg::SIG_TABLE[a_s_r[15:8]];
      dlf_pkg::ACT_TANH: act_val = dlf_pkg::TANH_TABLE[a_s_r[15:8]];
      default:           act_val = a_s_r[15] ? '0 : a_s_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      act_mode_r  <= dlf_pkg::ACT_RELU;
      ncount_r    <= dlf_pkg::CFG_W'(16);
      l1_r        <= 1'b0;
      l2_r        <= 1'b0;
      rem_r       <= '0;
      idx_r       <= '0;
      a_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == dlf_pkg::REG_ACT_MODE) act_mode_r <= cfg_data[1:0];
        else ncount_r <= cfg_data;
      end
      l1_r <= last_elem;
      l2_r <= l1_r;
      case (state_r)
        S_RUN: begin
          if (last_elem) state_r <= S_FLUSH;
        end
        S_FLUSH: begin
          if (l2_r) begin
            state_r <= S_UNLOAD;
            rem_r   <= cnt;
            idx_r   <= '0;
          end
        end
        S_UNLOAD: begin
          if (shift) begin
            rem_r <= rem_r - 1'b1;
            idx_r <= idx_r + 1'b1;
            if (rem_r == dlf_pkg::CFG_W'(1)) state_r <= S_RUN;
          end
        end
        default: state_r <= S_RUN;
      endcase
      if (a_take) a_v_r <= shift;
      if (b_can) out_valid_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      a_s_r    <= s_nxt;
      a_neu_r  <= idx_r;
      a_last_r <= (rem_r == dlf_pkg::CFG_W'(1));
    end
    if (b_can && a_v_r) begin
      out_val_r  <= act_val;
      out_neu_r  <= a_neu_r;
      out_last_r <= a_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_neuron = out_neu_r;
  assign out_value  = out_val_r;
  assign out_last   = out_last_r;

  // capture of the sums only happens while draining
  a_cap_flush: assert property (@(posedge clk) disable iff (!rst_n)
    l2_r |-> state_r == S_FLUSH)
    else $error("accumulator capture outside flush");

  // nothing left to unload once accepting again
  a_run_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> rem_r == '0)
    else $error("unload count not empty in run");

  // a shift always has a result left to hand out
  a_shift_rem: assert property (@(posedge clk) disable iff (!rst_n)
    shift |-> rem_r != '0)
    else $error("chain shifted with no result pending");

  // finishing stage does not lose a result while the output is stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && !b_can |=> a_v_r && $stable(a_s_r))
    else $error("finishing stage dropped a result");

endmodule

[sv/dlf_ram.sv]
module dlf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/dlf_cell.sv]
module dlf_cell #(
  parameter int INPUTS = dlf_pkg::INPUTS_DEF,
  parameter int IDX    = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dlf_pkg::cell_bus_t bus,
  input  logic              active,
  input  dlf_pkg::hold_t    hold_in,
  output dlf_pkg::hold_t    hold_out
);

  localparam int AW = (INPUTS > 1) ? $clog2(INPUTS) : 1;

  logic                        hit, pos_ok, we, re;
  logic [AW-1:0]               addr;
  logic [dlf_pkg::VAL_W-1:0]   w_rd;
  logic                        v1_r, v2_r;
  logic [dlf_pkg::VAL_W-1:0]   sample_r, bias_r;
  logic signed [31:0]          prod_r;
  logic [dlf_pkg::ACC_W-1:0]   acc_r, acc_nxt, acc_sum;
  dlf_pkg::hold_t              hold_r, hold_nxt;

  assign hit    = (bus.sel == dlf_pkg::SEL_W'(IDX));
  assign pos_ok = (32'(bus.pos) < INPUTS);
  assign we     = bus.load_w & hit & pos_ok;
  assign re     = bus.elem & active & pos_ok;
  assign addr   = AW'(bus.pos);

  dlf_ram #(.WIDTH(dlf_pkg::VAL_W), .DEPTH(INPUTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (bus.value),
    .re    (re),
    .raddr (addr),
    .rdata (w_rd)
  );

  always_comb begin
    acc_sum = acc_r + (v2_r ? {{(dlf_pkg::ACC_W-32){prod_r[31]}}, prod_r}
                            : {dlf_pkg::ACC_W{1'b0}});
    acc_nxt = bus.cap ? '0 : acc_sum;
    if (bus.cap) begin
      hold_nxt = '{acc: acc_sum, bias: bias_r};
    end else if (bus.shift) begin
      hold_nxt = hold_in;
    end else begin
      hold_nxt = hold_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      v1_r  <= re;
      v2_r  <= v1_r;
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (re) sample_r <= bus.value;
    prod_r <= $signed(w_rd) * $signed(sample_r);
    if (bus.load_b && hit) bias_r <= bus.value;
    hold_r <= hold_nxt;
  end

  assign hold_out = hold_r;

endmodule

[tb/tb_dense_layer_forward.sv]
`timescale 1ns / 100ps

module tb_dense_layer_forward;

  // codes the block leaves unused
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // one input item as it goes on the wire
  typedef struct {
    logic [1:0]  cmd;
    logic [3:0]  sel;
    logic [5:0]  pos;
    logic [15:0] val;
    logic        last;
    bit          typed;   // want holds a hand-worked result
    logic [15:0] want;
  } item_t;

  // one activation we are waiting for
  typedef struct {
    logic [3:0]  neuron;
    logic [15:0] value;
    logic        last;
  } act_out_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_cmd;
  logic [dlf_pkg::SEL_W-1:0] in_neuron_sel;
  logic [dlf_pkg::POS_W-1:0] in_input_pos;
  logic signed [dlf_pkg::VAL_W-1:0] in_value;
  logic in_last;
  logic out_valid;
  logic out_stall;
  logic [dlf_pkg::SEL_W-1:0] out_neuron;
  logic signed [dlf_pkg::VAL_W-1:0] out_value;
  logic out_last;
  logic cfg_wr_en;
  logic cfg_index;
  logic [dlf_pkg::CFG_W-1:0] cfg_data;

  dense_layer_forward i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_neuron_sel(in_neuron_sel), .in_input_pos(in_input_pos),
    .in_value(in_value), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_neuron(out_neuron),
    .out_value(out_value), .out_last(out_last),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // --- shadow of the layer ---
  logic [1:0]         mode_q;
  logic [4:0]         count_q;
  logic signed [15:0] wgt [16][64];
  logic signed [15:0] bia [16];
  logic [39:0]        acc [16];
  bit                 wseen [16][64];
  bit                 bseen [16];
  logic [15:0]        sig_lut [256];
  logic [15:0]        tanh_lut [256];

  act_out_t pending[$];
  int errors;
  int sent;
  int cycles;
  bit burst;         // sender offers back to back
  bit hold_req;      // ask the receiver for a long hold-off

  // Q4.60 helpers for the activation tables
  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[123:60];
  endfunction

  function automatic logic [15:0] fx_ratio(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = num / den;
    r = num % den;
    for (int i = 0; i < 13; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return 16'((q + 64'd1) >> 1);
  endfunction

  task automatic make_luts();
    logic [63:0] one;
    logic [63:0] ex;
    logic [63:0] term;
    logic [63:0] pw [129];
    logic [63:0] p;
    logic [63:0] p2;
    logic [15:0] t;
    int k;
    one = 64'd1 << 60;
    ex = one;
    term = one;
    // e^(-1/16) by its series
    for (int n = 1; n <= 20; n++) begin
      term = term / (16 * n);
      if (n % 2) ex = ex - term;
      else ex = ex + term;
    end
    pw[0] = one;
    for (int n = 1; n <= 128; n++) pw[n] = fx_mul(pw[n-1], ex);
    for (int i = 0; i < 256; i++) begin
      k = (i < 128) ? i : i - 256;
      p = pw[(k < 0) ? -k : k];
      p2 = fx_mul(p, p);
      sig_lut[i] = fx_ratio((k >= 0) ? one : p, one + p);
      t = fx_ratio(one - p2, one + p2);
      tanh_lut[i] = (k < 0) ? -t : t;
    end
  endtask

  function automatic int used_neurons();
    if (count_q == 0) return 1;
    if (count_q > 16) return 16;
    return count_q;
  endfunction

  function automatic logic [15:0] activate(int n);
    longint y;
    longint s;
    logic [15:0] sq;
    y = longint'($signed(acc[n])) + longint'(bia[n]) * 4096;
    s = (y + 2048) >>> 12;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    sq = 16'(s);
    case (mode_q)
      dlf_pkg::ACT_SIG:  return sig_lut[sq[15:8]];
      dlf_pkg::ACT_TANH: return tanh_lut[sq[15:8]];
      default:           return sq[15] ? 16'd0 : sq;
    endcase
  endfunction

  // fold one accepted item into the shadow and queue what it yields
  task automatic absorb(item_t it);
    int c;
    act_out_t r;
    longint prod;
    c = used_neurons();
    case (it.cmd)
      dlf_pkg::CMD_WEIGHT: begin
        wgt[it.sel][it.pos] = it.val;
        wseen[it.sel][it.pos] = 1;
      end
      dlf_pkg::CMD_BIAS: begin
        bia[it.sel] = it.val;
        bseen[it.sel] = 1;
      end
      dlf_pkg::CMD_ELEM: begin
        for (int n = 0; n < c; n++) begin
          prod = longint'(wgt[n][it.pos]) * longint'($signed(it.val));
          acc[n] = acc[n] + 40'(prod);
        end
        if (it.last) begin
          for (int n = 0; n < c; n++) begin
            r.neuron = 4'(n);
            r.value = activate(n);
            r.last = (n == c - 1);
            if (it.typed && r.value !== it.want) begin
              $error("out_value: expected %0d by hand, shadow gives %0d",
                     it.want, r.value);
              errors++;
            end
            pending.push_back(r);
          end
          for (int n = 0; n < 16; n++) acc[n] = '0;
        end
      end
      default: ;
    endcase
  endtask

  // offer one item after a random gap, wait for it to be taken
  task automatic send(item_t it);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= it.cmd;
    in_neuron_sel <= it.sel;
    in_input_pos <= it.pos;
    in_value <= it.val;
    in_last <= it.last;
    do @(posedge clk); while (in_stall);
    absorb(it);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending.size() == 0);
    repeat (24) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [4:0] d);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == dlf_pkg::REG_ACT_MODE) mode_q = d[1:0];
    else count_q = d;
  endtask

  function automatic logic [15:0] pick_val();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 8191)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t mk(logic [1:0] c, logic [3:0] s, logic [5:0] p,
                               logic [15:0] v, logic l);
    item_t it;
    it.cmd = c;
    it.sel = s;
    it.pos = p;
    it.val = v;
    it.last = l;
    it.typed = 0;
    it.want = '0;
    return it;
  endfunction

  // loads for whatever the next vector reads, then the vector itself
  task automatic run_vector(int len, int maxpos);
    int c;
    logic [5:0] ps [$];
    item_t it;
    c = used_neurons();
    for (int i = 0; i < len; i++) ps.push_back(6'($urandom_range(0, maxpos)));
    foreach (ps[i])
      for (int n = 0; n < c; n++)
        if (!wseen[n][ps[i]] || $urandom_range(0, 5) == 0)
          send(mk(dlf_pkg::CMD_WEIGHT, 4'(n), ps[i], pick_val(), 1'($urandom)));
    for (int n = 0; n < c; n++)
      if (!bseen[n] || $urandom_range(0, 3) == 0)
        send(mk(dlf_pkg::CMD_BIAS, 4'(n), 6'($urandom), pick_val(), 1'($urandom)));
    // some noise: unused command and loads anywhere
    if ($urandom_range(0, 3) == 0)
      send(mk(CMD_UNUSED, 4'($urandom), 6'($urandom), 16'($urandom), 1'($urandom)));
    if ($urandom_range(0, 3) == 0)
      send(mk(2'($urandom_range(0, 1)), 4'($urandom), 6'($urandom), pick_val(),
              1'($urandom)));
    foreach (ps[i]) begin
      it = mk(dlf_pkg::CMD_ELEM, 4'($urandom), ps[i], pick_val(), i == len - 1);
      send(it);
    end
  endtask

  // receiver: random stall before each item, plus one long hold-off
  initial begin
    int n;
    out_stall = 1'b1;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result checker
  always @(posedge clk) begin
    act_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("unexpected result: neuron %0d value %0d", out_neuron, out_value);
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_neuron !== e.neuron) begin
          $error("out_neuron: expected %0d, got %0d", e.neuron, out_neuron);
          errors++;
        end
        if (out_value !== e.value) begin
          $error("out_value: expected %0d, got %0d", $signed(e.value), out_value);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("out_last: expected %0d, got %0d", e.last, out_last);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 1500000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  item_t dir [$];

  initial begin
    item_t it;
    errors = 0;
    sent = 0;
    cycles = 0;
    burst = 0;
    hold_req = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = dlf_pkg::CMD_WEIGHT;
    in_neuron_sel = '0;
    in_input_pos = '0;
    in_value = '0;
    in_last = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = dlf_pkg::REG_ACT_MODE;
    cfg_data = '0;
    mode_q = dlf_pkg::ACT_RELU;
    count_q = 5'd16;
    for (int n = 0; n < 16; n++) begin
      acc[n] = '0;
      bia[n] = '0;
      bseen[n] = 0;
      for (int p = 0; p < 64; p++) begin
        wgt[n][p] = '0;
        wseen[n][p] = 0;
      end
    end
    make_luts();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, one neuron, ReLU
    cfg_write(dlf_pkg::REG_NEURON_COUNT, 5'd1);
    dir.push_back(mk(dlf_pkg::CMD_BIAS, 4'd0, 6'd0, 16'h0000, 1'b0));
    dir.push_back(mk(dlf_pkg::CMD_WEIGHT, 4'd0, 6'd0, 16'h1000, 1'b1));  // weight 1.0
    it = mk(dlf_pkg::CMD_ELEM, 4'd0, 6'd0, 16'h7FFF, 1'b1);              // top of range
    it.typed = 1; it.want = 16'h7FFF; dir.push_back(it);
    dir.push_back(mk(CMD_UNUSED, 4'd15, 6'd63, 16'hFFFF, 1'b1));         // ignored
    it = mk(dlf_pkg::CMD_ELEM, 4'd15, 6'd0, 16'h8000, 1'b1);             // negative, clipped
    it.typed = 1; it.want = 16'h0000; dir.push_back(it);
    dir.push_back(mk(dlf_pkg::CMD_WEIGHT, 4'd15, 6'd63, 16'h7FFF, 1'b1));
    dir.push_back(mk(dlf_pkg::CMD_BIAS, 4'd15, 6'd63, 16'h8000, 1'b1));
    dir.push_back(mk(dlf_pkg::CMD_WEIGHT, 4'd0, 6'd63, 16'h7FFF, 1'b0));
    dir.push_back(mk(dlf_pkg::CMD_ELEM, 4'd0, 6'd63, 16'h7FFF, 1'b0));
    it = mk(dlf_pkg::CMD_ELEM, 4'd0, 6'd63, 16'h7FFF, 1'b1);             // saturates high
    it.typed = 1; it.want = 16'h7FFF; dir.push_back(it);
    dir.push_back(mk(dlf_pkg::CMD_BIAS, 4'd0, 6'd0, 16'h8000, 1'b1));
    it = mk(dlf_pkg::CMD_ELEM, 4'd0, 6'd0, 16'h0000, 1'b1);              // bias -8 only
    it.typed = 1; it.want = 16'h0000; dir.push_back(it);
    dir.push_back(mk(dlf_pkg::CMD_BIAS, 4'd0, 6'd0, 16'h0800, 1'b0));
    dir.push_back(mk(dlf_pkg::CMD_ELEM, 4'd0, 6'd0, 16'hFFFF, 1'b1));    // rounding near half
    dir.push_back(mk(dlf_pkg::CMD_ELEM, 4'd0, 6'd63, 16'h8000, 1'b0));
    dir.push_back(mk(dlf_pkg::CMD_ELEM, 4'd0, 6'd0, 16'h8000, 1'b1));    // saturates low
    foreach (dir[i]) send(dir[i]);
    drain();
    // same vectors through both tables
    cfg_write(dlf_pkg::REG_ACT_MODE, {3'b0, dlf_pkg::ACT_SIG});
    foreach (dir[i]) if (dir[i].cmd == dlf_pkg::CMD_ELEM) begin
      it = dir[i]; it.typed = 0; send(it);
    end
    drain();
    cfg_write(dlf_pkg::REG_ACT_MODE, {3'b0, dlf_pkg::ACT_TANH});
    foreach (dir[i]) if (dir[i].cmd == dlf_pkg::CMD_ELEM) begin
      it = dir[i]; it.typed = 0; send(it);
    end
    drain();

    // random phases; counts include 0 and values past the top
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          cfg_write(dlf_pkg::REG_ACT_MODE, {3'b0, dlf_pkg::ACT_SIG});
          cfg_write(dlf_pkg::REG_NEURON_COUNT, 5'd16);
        end
        1: begin
          cfg_write(dlf_pkg::REG_ACT_MODE, {3'b0, dlf_pkg::ACT_TANH});
          cfg_write(dlf_pkg::REG_NEURON_COUNT, 5'd0);
        end
        2: begin
          cfg_write(dlf_pkg::REG_ACT_MODE, {3'b0, ACT_UNUSED});
          cfg_write(dlf_pkg::REG_NEURON_COUNT, 5'd17);
        end
        3: begin
          cfg_write(dlf_pkg::REG_ACT_MODE, {3'b0, dlf_pkg::ACT_RELU});
          cfg_write(dlf_pkg::REG_NEURON_COUNT, 5'd31);
        end
        default: begin
          cfg_write(dlf_pkg::REG_ACT_MODE, 5'($urandom_range(0, 3)));
          cfg_write(dlf_pkg::REG_NEURON_COUNT, 5'($urandom_range(0, 31)));
        end
      endcase
      for (int v = 0; v < 3; v++) begin
        burst = ($urandom_range(0, 2) == 0);
        // fill the block while the receiver holds off
        if (ph == 3 && v == 1) begin
          burst = 1;
          hold_req = 1;
        end
        if ($urandom_range(0, 9) == 0) run_vector($urandom_range(8, 16), 3);
        else run_vector($urandom_range(1, 4), $urandom_range(0, 1) ? 63 : 3);
      end
      burst = 0;
      drain();
      if (sent > 410 && ph >= 4) break;
    end

    wait (pending.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[dense_layer_forward.f]
sv/dlf_pkg.sv
sv/dlf_ram.sv
sv/dlf_cell.sv
sv/dense_layer_forward.sv
tb/tb_dense_layer_forward.sv
